[design/btlpm_pkg.sv]
package btlpm_pkg;

	localparam int ADDR_BITS = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic                 cmd;
		logic [ADDR_BITS-1:0] address;
		logic [5:0]           prefix_len;
		logic [31:0]          hop_in;
		logic [7:0]           port_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] hop_out;
		logic [7:0]  port_out;
	} rsp_t;

endpackage

[design/binary_trie_longest_prefix_match_top.sv]
// Unibit binary trie for IPv4 longest-prefix match. A command is taken when start is high and
// busy is low; an insert (cmd 0) adds the leading prefix_len bits of address as a route with
// hop_in and port_in, and a lookup (cmd 1) returns the route of the longest stored prefix of
// address. The trie walks one level per cycle, bounded by the read latency of the node memory;
// it walks at most prefix_len levels, saturated at 32, for an insert and up to 32 for a lookup.
// Each result is shown for one cycle with done high, and the receiver cannot stall it.
// After reset the block sweeps the node memory clear, one node per cycle, and holds busy high
// until the sweep is done, before it takes the first command.
module binary_trie_longest_prefix_match_top #(
	parameter int NODE_COUNT = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  btlpm_pkg::req_t   req,
	output logic              busy,
	output logic              done,
	output btlpm_pkg::rsp_t   rsp
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int FW = $clog2(NODE_COUNT + 1);
	localparam int EW = 2 * IW + 1;
	localparam int DW = $clog2(btlpm_pkg::ADDR_BITS + 1);
	localparam int AB = btlpm_pkg::ADDR_BITS;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	// Node entry: right child, left child, route mark. Child index zero means no child.
	logic [EW-1:0] node_mem [NODE_COUNT];
	logic [39:0]   route_mem [NODE_COUNT];
	logic [EW-1:0] node_rd_q;
	logic [39:0]   route_rd_q;

	logic [1:0]    state_q;
	logic [IW-1:0] clr_q;
	logic          cmd_q;
	logic [AB-1:0] addr_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] plen_q;
	logic [31:0]   hop_q;
	logic [7:0]    port_q;
	logic [IW-1:0] cur_q;
	logic [FW-1:0] free_q;
	logic          found_q;
	logic [31:0]   best_hop_q;
	logic [7:0]    best_port_q;
	logic          done_q;
	btlpm_pkg::rsp_t rsp_q;

	logic          accept;
	logic          dir_bit;
	logic [IW-1:0] child;
	logic          last_lvl;
	logic          store_full;
	logic          found_now;
	logic [31:0]   hop_now;
	logic [7:0]    port_now;
	logic          nd_we;
	logic [IW-1:0] nd_waddr;
	logic [EW-1:0] nd_wdata;
	logic          rt_we;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          advance;
	logic          alloc;
	logic          finish;
	btlpm_pkg::rsp_t fin_rsp;

	assign accept     = start && (state_q == ST_IDLE);
	assign dir_bit    = addr_q[AB-1];
	assign child      = dir_bit ? node_rd_q[EW-1:IW+1] : node_rd_q[IW:1];
	assign last_lvl   = (depth_q == plen_q);
	assign store_full = (free_q >= FW'(NODE_COUNT));
	assign found_now  = found_q || node_rd_q[0];
	assign hop_now    = node_rd_q[0] ? route_rd_q[39:8] : best_hop_q;
	assign port_now   = node_rd_q[0] ? route_rd_q[7:0] : best_port_q;

	always_comb begin
		nd_we    = 1'b0;
		nd_waddr = cur_q;
		nd_wdata = node_rd_q;
		rt_we    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = child;
		advance  = 1'b0;
		alloc    = 1'b0;
		finish   = 1'b0;
		fin_rsp  = '0;
		case (state_q)
			ST_CLR: begin
				nd_we    = 1'b1;
				nd_waddr = clr_q;
				nd_wdata = '0;
			end
			ST_IDLE: begin
				rd_en   = accept;
				rd_addr = '0;
			end
			ST_WALK: begin
				if (cmd_q == btlpm_pkg::CMD_INSERT) begin
					if (last_lvl) begin
						nd_we    = 1'b1;
						nd_wdata = {node_rd_q[EW-1:1], 1'b1};
						rt_we    = 1'b1;
						finish   = 1'b1;
						fin_rsp.status = btlpm_pkg::STATUS_OK;
					end else if (child == '0) begin
						if (store_full) begin
							finish = 1'b1;
							fin_rsp.status = btlpm_pkg::STATUS_FULL;
						end else begin
							// Link a fresh node; it reads as empty since the sweep cleared it.
							nd_we = 1'b1;
							if (dir_bit) begin
								nd_wdata = {free_q[IW-1:0], node_rd_q[IW:0]};
							end else begin
								nd_wdata = {node_rd_q[EW-1:IW+1], free_q[IW-1:0], node_rd_q[0]};
							end
							alloc   = 1'b1;
							advance = 1'b1;
							rd_en   = 1'b1;
							rd_addr = free_q[IW-1:0];
						end
					end else begin
						advance = 1'b1;
						rd_en   = 1'b1;
					end
				end else begin
					if (last_lvl || (child == '0)) begin
						finish = 1'b1;
						fin_rsp.status   = found_now ? btlpm_pkg::STATUS_OK : btlpm_pkg::STATUS_MISS;
						fin_rsp.hop_out  = found_now ? hop_now : 32'd0;
						fin_rsp.port_out = found_now ? port_now : 8'd0;
					end else begin
						advance = 1'b1;
						rd_en   = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nd_we) begin
			node_mem[nd_waddr] <= nd_wdata;
		end
		if (rd_en) begin
			node_rd_q <= node_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rt_we) begin
			route_mem[cur_q] <= {hop_q, port_q};
		end
		if (rd_en) begin
			route_rd_q <= route_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			free_q  <= FW'(1);
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						found_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (cmd_q == btlpm_pkg::CMD_LOOKUP) begin
						found_q <= found_now;
					end
					if (alloc) begin
						free_q <= free_q + 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			addr_q  <= req.address;
			hop_q   <= req.hop_in;
			port_q  <= req.port_in;
			cur_q   <= '0;
			depth_q <= '0;
			if (req.cmd == btlpm_pkg::CMD_INSERT) begin
				plen_q <= (req.prefix_len > 6'(AB)) ? DW'(AB) : DW'(req.prefix_len);
			end else begin
				plen_q <= DW'(AB);
			end
		end else if (advance) begin
			cur_q   <= rd_addr;
			depth_q <= depth_q + 1'b1;
			addr_q  <= {addr_q[AB-2:0], 1'b0};
		end
		if (state_q == ST_WALK) begin
			best_hop_q  <= hop_now;
			best_port_q <= port_now;
		end
		if (finish) begin
			rsp_q <= fin_rsp;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[design/btlpm_checker.sv]
module btlpm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input btlpm_pkg::req_t req,
	input logic            busy,
	input logic            done,
	input btlpm_pkg::rsp_t rsp
);

	// A command transfer always starts a walk.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy not raised after command transfer");

	// A result ends the walk: it comes only after busy and frees the block.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a walk");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == btlpm_pkg::STATUS_OK || rsp.status == btlpm_pkg::STATUS_MISS
			|| rsp.status == btlpm_pkg::STATUS_FULL))
		else $error("undefined status code");

	// A miss or a full store carries no route.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == btlpm_pkg::STATUS_MISS || rsp.status == btlpm_pkg::STATUS_FULL))
		|-> (rsp.hop_out == 32'd0 && rsp.port_out == 8'd0))
		else $error("route data on a result without match");

endmodule

bind binary_trie_longest_prefix_match_top btlpm_checker u_btlpm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.req    (req),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
